FILE: hw/rtl/orsl_pkg.sv
// Shared types, codes and constants of the overwriting record ring.
`default_nettype none

package orsl_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int NUMBER_W  = 16;
   localparam int PAYLOAD_W = 64;
   localparam int SLOT_W    = 6;
   localparam int FILL_W    = 7;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int LIMIT_W   = 8;
   localparam int MARGIN_W  = 4;
   localparam int COUNT_W   = 8;

   localparam int WRAP_MODULUS = 65535;
   localparam int FOLD_BASE    = 65536;

   localparam logic [LIMIT_W-1:0]  LOOKBACK_LIMIT_RESET = 8'd100;
   localparam logic [MARGIN_W-1:0] REORDER_MARGIN_RESET = 4'd3;
   localparam logic [NUMBER_W-1:0] WRAP_THRESHOLD_RESET = 16'd65200;

   localparam logic [CSR_IDX_W-1:0] CSR_LOOKBACK_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REORDER_MARGIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_THRESHOLD = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_LATEST = 3'd1,
      OP_LOOKUP = 3'd2,
      OP_DRAIN  = 3'd3,
      OP_SIZE   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NEWEST,
      ST_REDUCE,
      ST_FOLD,
      ST_LIMIT,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [NUMBER_W-1:0]    number;
      logic [PAYLOAD_W-1:0]   payload;
   } cmd_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]     lookback_limit;
      logic [MARGIN_W-1:0]    reorder_margin;
      logic [NUMBER_W-1:0]    wrap_threshold;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [NUMBER_W-1:0]    number;
      logic [PAYLOAD_W-1:0]   payload;
      logic [SLOT_W-1:0]      slot;
      logic [FILL_W-1:0]      fill;
      logic                   last;
   } rsp_type;

   function automatic rsp_type make_rsp(
      input logic [STATUS_W-1:0]  status,
      input logic [NUMBER_W-1:0]  number,
      input logic [PAYLOAD_W-1:0] payload,
      input logic [SLOT_W-1:0]    slot,
      input logic [FILL_W-1:0]    fill,
      input logic                 last
   );
      rsp_type r;
      r.status  = status;
      r.number  = number;
      r.payload = payload;
      r.slot    = slot;
      r.fill    = fill;
      r.last    = last;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/orsl_front.sv
// Command front end: decodes opcodes, drops unknown ones, queues the rest.
`default_nettype none

module orsl_front import orsl_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [2:0]           opcode,
   input  wire logic [NUMBER_W-1:0]  packet_number,
   input  wire logic [PAYLOAD_W-1:0] payload,
   output logic                      busy,
   output logic                      cmd_valid,
   output cmd_type                   cmd,
   input  wire logic                 cmd_pop
);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                known_op;
   logic                push;
   logic                pop;
   cmd_type             new_cmd;

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign known_op  = (opcode <= 3'(OP_SIZE));
   assign push      = start && !busy && known_op;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op      = op_type'(opcode);
      new_cmd.number  = packet_number;
      new_cmd.payload = payload;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/orsl_back.sv
// Command back end: record store, ring pointers, lookup scan and drain sequencer.
`default_nettype none

module orsl_back import orsl_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_strobe,
   output rsp_type      rsp
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [PTR_W-1:0]        wp_ff, wp_in;
   logic [PTR_W-1:0]        oldest_ff, oldest_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [PTR_W-1:0]        scan_ptr_ff, scan_ptr_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [17:0]      diff_ff, diff_in;
   logic [NUMBER_W-1:0]     dist_ff, dist_in;
   logic                    hit_ff, hit_in;
   logic [PAYLOAD_W-1:0]    hit_pay_ff, hit_pay_in;
   logic [PTR_W-1:0]        hit_slot_ff, hit_slot_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [NUMBER_W-1:0]     num_mem_ff [DEPTH];
   logic [PAYLOAD_W-1:0]    pay_mem_ff [DEPTH];
   logic [DEPTH-1:0]        valid_ff;
   logic [NUMBER_W-1:0]     rd_num_raw_ff;
   logic [PAYLOAD_W-1:0]    rd_pay_raw_ff;
   logic                    rd_valid_ff;
   logic [PTR_W-1:0]        rd_slot_ff;

   logic                    mem_we;
   logic                    rd_en;
   logic [PTR_W-1:0]        rd_addr;
   logic [NUMBER_W-1:0]     rd_num;
   logic [PAYLOAD_W-1:0]    rd_pay;
   logic [PTR_W-1:0]        newest;
   logic                    occ_zero;
   logic                    occ_full;
   logic                    newest_match;
   logic                    scan_match;
   logic [16:0]             abs_val;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_SLOT : p - 1'b1;
   endfunction

   // Entries never written read as zero, as after a cleared store.
   assign rd_num       = rd_valid_ff ? rd_num_raw_ff : '0;
   assign rd_pay       = rd_valid_ff ? rd_pay_raw_ff : '0;
   assign newest       = ptr_dec(wp_ff);
   assign occ_zero     = (occ_ff == '0);
   assign occ_full     = (occ_ff == OCC_W'(DEPTH));
   assign newest_match = (rd_num == cmd_ff.number);
   assign scan_match   = (rd_num == cmd_ff.number);
   assign abs_val      = diff_ff[17] ? 17'(-diff_ff) : diff_ff[16:0];

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_PUSH, OP_SIZE:    state_in = ST_IDLE;
               OP_LATEST, OP_LOOKUP: state_in = occ_zero ? ST_IDLE : ST_NEWEST;
               OP_DRAIN:            state_in = occ_zero ? ST_IDLE : ST_DRAIN;
               default:             state_in = ST_IDLE;
            endcase
         end
         ST_NEWEST: begin
            if (cmd_ff.op == OP_LOOKUP && !newest_match) state_in = ST_REDUCE;
            else state_in = ST_IDLE;
         end
         ST_REDUCE: state_in = ST_FOLD;
         ST_FOLD:   state_in = ST_LIMIT;
         ST_LIMIT: begin
            state_in = (dist_ff > NUMBER_W'(cfg.lookback_limit)) ? ST_IDLE : ST_SCAN;
         end
         ST_SCAN: begin
            if (count_ff == '0) state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (count_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      wp_in         = wp_ff;
      oldest_in     = oldest_ff;
      occ_in        = occ_ff;
      scan_ptr_in   = scan_ptr_ff;
      count_in      = count_ff;
      diff_in       = diff_ff;
      dist_in       = dist_ff;
      hit_in        = hit_ff;
      hit_pay_in    = hit_pay_ff;
      hit_slot_in   = hit_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_PUSH: begin
                  mem_we = 1'b1;
                  wp_in  = ptr_inc(wp_ff);
                  if (occ_full) oldest_in = ptr_inc(oldest_ff);
                  else occ_in = occ_ff + 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_in = make_rsp(STATUS_OK, '0, '0, SLOT_W'(wp_ff),
                                    FILL_W'(occ_full ? occ_ff : occ_ff + 1'b1), 1'b1);
               end
               OP_SIZE: begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = make_rsp(STATUS_OK, '0, '0, '0, FILL_W'(occ_ff), 1'b1);
               end
               OP_LATEST, OP_LOOKUP: begin
                  if (occ_zero) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = make_rsp(STATUS_EMPTY, '0, '0, '0, '0, 1'b1);
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = newest;
                  end
               end
               OP_DRAIN: begin
                  if (occ_zero) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = make_rsp(STATUS_EMPTY, '0, '0, '0, '0, 1'b1);
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = oldest_ff;
                     scan_ptr_in = ptr_inc(oldest_ff);
                     count_in    = COUNT_W'(occ_ff) - 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_NEWEST: begin
            if (cmd_ff.op == OP_LATEST || newest_match) begin
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(STATUS_OK, rd_num, rd_pay, SLOT_W'(rd_slot_ff),
                                 FILL_W'(occ_ff), 1'b1);
            end else begin
               diff_in = $signed({2'b00, rd_num}) - $signed({2'b00, cmd_ff.number})
                         + $signed({14'd0, cfg.reorder_margin});
            end
         end
         ST_REDUCE: begin
            // Distance modulo 65535; magnitude never reaches twice that.
            if (abs_val >= 17'(WRAP_MODULUS)) dist_in = 16'(abs_val - 17'(WRAP_MODULUS));
            else dist_in = abs_val[15:0];
         end
         ST_FOLD: begin
            if (dist_ff > cfg.wrap_threshold) begin
               dist_in = 16'(17'(FOLD_BASE) - {1'b0, dist_ff});
            end
         end
         ST_LIMIT: begin
            if (dist_ff > NUMBER_W'(cfg.lookback_limit)) begin
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(STATUS_NOT_FOUND, '0, '0, '0, FILL_W'(occ_ff), 1'b1);
            end else begin
               // Walk from the newest slot backwards; the farthest match wins.
               rd_en       = 1'b1;
               rd_addr     = newest;
               scan_ptr_in = ptr_dec(newest);
               count_in    = dist_ff[COUNT_W-1:0];
               hit_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_match) begin
               hit_in      = 1'b1;
               hit_pay_in  = rd_pay;
               hit_slot_in = rd_slot_ff;
            end
            if (count_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ptr_ff;
               scan_ptr_in = ptr_dec(scan_ptr_ff);
               count_in    = count_ff - 1'b1;
            end else begin
               rsp_strobe_in = 1'b1;
               if (scan_match) begin
                  rsp_in = make_rsp(STATUS_OK, cmd_ff.number, rd_pay, SLOT_W'(rd_slot_ff),
                                    FILL_W'(occ_ff), 1'b1);
               end else if (hit_ff) begin
                  rsp_in = make_rsp(STATUS_OK, cmd_ff.number, hit_pay_ff,
                                    SLOT_W'(hit_slot_ff), FILL_W'(occ_ff), 1'b1);
               end else begin
                  rsp_in = make_rsp(STATUS_NOT_FOUND, '0, '0, '0, FILL_W'(occ_ff), 1'b1);
               end
            end
         end
         ST_DRAIN: begin
            rsp_strobe_in = 1'b1;
            rsp_in = make_rsp(STATUS_OK, rd_num, rd_pay, SLOT_W'(rd_slot_ff), '0,
                              (count_ff == '0));
            if (count_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ptr_ff;
               scan_ptr_in = ptr_inc(scan_ptr_ff);
               count_in    = count_ff - 1'b1;
            end else begin
               wp_in     = '0;
               oldest_in = '0;
               occ_in    = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         oldest_ff     <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         oldest_ff     <= oldest_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (mem_we) valid_ff[wp_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      scan_ptr_ff <= scan_ptr_in;
      count_ff    <= count_in;
      diff_ff     <= diff_in;
      dist_ff     <= dist_in;
      hit_ff      <= hit_in;
      hit_pay_ff  <= hit_pay_in;
      hit_slot_ff <= hit_slot_in;
      rsp_ff      <= rsp_in;
   end

   // Record store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         num_mem_ff[wp_ff] <= cmd_ff.number;
         pay_mem_ff[wp_ff] <= cmd_ff.payload;
      end
      if (rd_en) begin
         rd_num_raw_ff <= num_mem_ff[rd_addr];
         rd_pay_raw_ff <= pay_mem_ff[rd_addr];
         rd_valid_ff   <= valid_ff[rd_addr];
         rd_slot_ff    <= rd_addr;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/overwrite_ring_with_sequence_lookup.sv
// Top level of the overwriting record ring with packet-number lookup.
//
// Commands enter on req_* when start is high and busy is low. Opcodes:
// push, latest, lookup, drain, size; unknown opcodes are taken and dropped.
// A two-entry command queue sits in front of the executing back end, so
// busy rises only when two commands wait behind the one being executed.
// Results leave on rsp_* for one cycle each, marked by rsp_strobe; the
// receiver cannot stall them. rsp_last marks the final result of a command.
// Path from acceptance to the first result of each kind of command:
//   push, size, and latest/lookup/drain on an empty ring: the execute state
//   latest and lookup hitting the newest record: a read of the newest slot
//   lookup beyond the lookback limit: that read, then reduce, fold, limit
//   lookup scan: as above, then one store read per slot visited
//   drain of n records: oldest first, one record per cycle.
// The back end executes one command at a time; the single read port
// of the record store sets the pace of scans and drains.
// csr_* writes the lookback limit, reorder margin and wrap threshold;
// it is always ready. Reset empties the ring, marks every slot as zero
// and loads the register defaults.
`default_nettype none

module overwrite_ring_with_sequence_lookup import orsl_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [2:0]           req_opcode,
   input  wire logic [NUMBER_W-1:0]  req_packet_number,
   input  wire logic [PAYLOAD_W-1:0] req_payload,
   output logic                      rsp_strobe,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [NUMBER_W-1:0]       rsp_packet_number_res,
   output logic [PAYLOAD_W-1:0]      rsp_payload_res,
   output logic [SLOT_W-1:0]         rsp_slot_index,
   output logic [FILL_W-1:0]         rsp_fill_count,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   rsp_type rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOOKBACK_LIMIT: cfg_in.lookback_limit = csr_wdata[LIMIT_W-1:0];
            CSR_REORDER_MARGIN: cfg_in.reorder_margin = csr_wdata[MARGIN_W-1:0];
            CSR_WRAP_THRESHOLD: cfg_in.wrap_threshold = csr_wdata[NUMBER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lookback_limit <= LOOKBACK_LIMIT_RESET;
         cfg_ff.reorder_margin <= REORDER_MARGIN_RESET;
         cfg_ff.wrap_threshold <= WRAP_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   orsl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .opcode        (req_opcode),
      .packet_number (req_packet_number),
      .payload       (req_payload),
      .busy          (busy),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   orsl_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_status            = rsp.status;
   assign rsp_packet_number_res = rsp.number;
   assign rsp_payload_res       = rsp.payload;
   assign rsp_slot_index        = rsp.slot;
   assign rsp_fill_count        = rsp.fill;
   assign rsp_last              = rsp.last;

endmodule

`default_nettype wire

FILE: dv/ring_record_checker.sv
// Checker for the record ring: tracks commands and settings, predicts results and compares.
`timescale 1ns / 100ps

module ring_record_checker import orsl_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [2:0]           req_opcode,
   input  logic [NUMBER_W-1:0]  req_packet_number,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic                 rsp_strobe,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic [NUMBER_W-1:0]  rsp_packet_number_res,
   input  logic [PAYLOAD_W-1:0] rsp_payload_res,
   input  logic [SLOT_W-1:0]    rsp_slot_index,
   input  logic [FILL_W-1:0]    rsp_fill_count,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   mismatch_count,
   output int                   outstanding_count
);

   logic [NUMBER_W-1:0]  ring_number  [DEPTH];
   logic [PAYLOAD_W-1:0] ring_payload [DEPTH];
   int unsigned          head_slot;
   int unsigned          tail_slot;
   int unsigned          held_count;
   logic [LIMIT_W-1:0]   cfg_limit;
   logic [MARGIN_W-1:0]  cfg_margin;
   logic [NUMBER_W-1:0]  cfg_threshold;
   rsp_type              expected_records [$];
   int                   errors = 0;

   function automatic void clear_model();
      for (int i = 0; i < DEPTH; i++) begin
         ring_number[i]  = '0;
         ring_payload[i] = '0;
      end
      head_slot     = 0;
      tail_slot     = 0;
      held_count    = 0;
      cfg_limit     = LOOKBACK_LIMIT_RESET;
      cfg_margin    = REORDER_MARGIN_RESET;
      cfg_threshold = WRAP_THRESHOLD_RESET;
      expected_records.delete();
   endfunction

   function automatic void expect_record(input logic [STATUS_W-1:0] status,
                                         input logic [NUMBER_W-1:0] number,
                                         input logic [PAYLOAD_W-1:0] payload,
                                         input int unsigned slot,
                                         input int unsigned fill,
                                         input logic last);
      rsp_type r;
      r.status  = status;
      r.number  = number;
      r.payload = payload;
      r.slot    = SLOT_W'(slot);
      r.fill    = FILL_W'(fill);
      r.last    = last;
      expected_records.insert(expected_records.size(), r);
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("[%0t] ring check: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [PAYLOAD_W-1:0] got,
                              input logic [PAYLOAD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   task automatic compare_record();
      rsp_type want;
      if (expected_records.size() == 0) begin
         report_mismatch($sformatf("result with nothing outstanding, status %0d slot %0d",
                                   rsp_status, rsp_slot_index));
      end else begin
         want = expected_records.pop_front();
         check_field("status", rsp_status, want.status);
         check_field("packet number", rsp_packet_number_res, want.number);
         check_field("payload", rsp_payload_res, want.payload);
         check_field("slot index", rsp_slot_index, want.slot);
         check_field("fill count", rsp_fill_count, want.fill);
         check_field("last", rsp_last, want.last);
      end
   endtask

   function automatic void apply_setting();
      case (csr_index)
         CSR_LOOKBACK_LIMIT: cfg_limit     = csr_wdata[LIMIT_W-1:0];
         CSR_REORDER_MARGIN: cfg_margin    = csr_wdata[MARGIN_W-1:0];
         CSR_WRAP_THRESHOLD: cfg_threshold = csr_wdata;
         default: ;
      endcase
   endfunction

   function automatic void model_command(input logic [2:0] op,
                                         input logic [NUMBER_W-1:0] num,
                                         input logic [PAYLOAD_W-1:0] pay);
      int unsigned newest;
      int unsigned slot;
      int unsigned back_dist;
      int unsigned span;
      int unsigned step;
      int          diff;
      bit          hit;
      newest = (tail_slot + DEPTH - 1) % DEPTH;
      case (op)
         OP_PUSH: begin
            slot = tail_slot;
            // full ring: overwrite the oldest record
            if (held_count >= DEPTH) head_slot = (head_slot + 1) % DEPTH;
            else held_count++;
            ring_number[slot]  = num;
            ring_payload[slot] = pay;
            tail_slot = (slot + 1) % DEPTH;
            expect_record(STATUS_OK, '0, '0, slot, held_count, 1'b1);
         end
         OP_LATEST: begin
            if (held_count == 0) expect_record(STATUS_EMPTY, '0, '0, 0, 0, 1'b1);
            else expect_record(STATUS_OK, ring_number[newest], ring_payload[newest],
                               newest, held_count, 1'b1);
         end
         OP_LOOKUP: begin
            if (held_count == 0) begin
               expect_record(STATUS_EMPTY, '0, '0, 0, 0, 1'b1);
            end else begin
               diff = int'(ring_number[newest]) - int'(num);
               if (diff == 0) begin
                  expect_record(STATUS_OK, ring_number[newest], ring_payload[newest],
                                newest, held_count, 1'b1);
               end else begin
                  diff = diff + int'(cfg_margin);
                  span = (diff < 0 ? -diff : diff) % WRAP_MODULUS;
                  if (span > cfg_threshold) span = FOLD_BASE - span;
                  hit = 1'b0;
                  // walk from the farthest distance toward the newest slot
                  if (span <= cfg_limit) begin
                     for (step = 0; step <= span && !hit; step++) begin
                        back_dist = span - step;
                        slot = (newest + DEPTH - back_dist % DEPTH) % DEPTH;
                        if (ring_number[slot] == num) begin
                           hit = 1'b1;
                           expect_record(STATUS_OK, num, ring_payload[slot], slot,
                                         held_count, 1'b1);
                        end
                     end
                  end
                  if (!hit) expect_record(STATUS_NOT_FOUND, '0, '0, 0, held_count, 1'b1);
               end
            end
         end
         OP_DRAIN: begin
            if (held_count == 0) begin
               expect_record(STATUS_EMPTY, '0, '0, 0, 0, 1'b1);
            end else begin
               for (step = 0; step < held_count; step++) begin
                  slot = (head_slot + step) % DEPTH;
                  expect_record(STATUS_OK, ring_number[slot], ring_payload[slot], slot, 0,
                                step + 1 == held_count);
               end
               // slot contents stay behind for later lookups
               head_slot  = 0;
               tail_slot  = 0;
               held_count = 0;
            end
         end
         OP_SIZE: expect_record(STATUS_OK, '0, '0, 0, held_count, 1'b1);
         default: ;
      endcase
   endfunction

   // Results first, so a result never matches a command taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (rsp_strobe) compare_record();
         if (csr_valid && csr_ready) apply_setting();
         if (start && !busy) model_command(req_opcode, req_packet_number, req_payload);
      end
      mismatch_count    <= errors;
      outstanding_count <= expected_records.size();
   end

endmodule

FILE: dv/tb_overwrite_ring_with_sequence_lookup.sv
// Testbench top of the record ring: clock, reset, command and settings stimulus, verdict.
`timescale 1ns / 100ps

module tb_overwrite_ring_with_sequence_lookup;
   import orsl_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int STALL_LIMIT   = 2000;
   localparam int CSR_GAP       = 16;
   localparam int SETTLE_CYCLES = 300;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE      = 2'd3;
   localparam logic [2:0]           OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0]           OP_SPARE_LAST  = 3'd7;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 start             = 1'b0;
   logic [2:0]           req_opcode        = '0;
   logic [NUMBER_W-1:0]  req_packet_number = '0;
   logic [PAYLOAD_W-1:0] req_payload       = '0;
   logic                 csr_valid         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index         = '0;
   logic [CSR_DAT_W-1:0] csr_wdata         = '0;

   logic                 busy;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [NUMBER_W-1:0]  rsp_packet_number_res;
   logic [PAYLOAD_W-1:0] rsp_payload_res;
   logic [SLOT_W-1:0]    rsp_slot_index;
   logic [FILL_W-1:0]    rsp_fill_count;
   logic                 rsp_last;
   logic                 csr_ready;

   int                   mismatch_count;
   int                   outstanding_count;
   int                   stall_cycles = 0;
   logic [NUMBER_W-1:0]  seq_next;
   logic [NUMBER_W-1:0]  seq_last;

   overwrite_ring_with_sequence_lookup #(.DEPTH(DEPTH)) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_packet_number     (req_packet_number),
      .req_payload           (req_payload),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_packet_number_res (rsp_packet_number_res),
      .rsp_payload_res       (rsp_payload_res),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_fill_count        (rsp_fill_count),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   ring_record_checker #(.DEPTH(DEPTH)) i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_packet_number     (req_packet_number),
      .req_payload           (req_payload),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_packet_number_res (rsp_packet_number_res),
      .rsp_payload_res       (rsp_payload_res),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_fill_count        (rsp_fill_count),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatch_count        (mismatch_count),
      .outstanding_count     (outstanding_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Advance the stall counter only on cycles that move no transaction.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic issue_command(input logic [2:0] op, input logic [NUMBER_W-1:0] number,
                                input logic [PAYLOAD_W-1:0] payload);
      start             <= 1'b1;
      req_opcode        <= op;
      req_packet_number <= number;
      req_payload       <= payload;
      do @(posedge clock); while (busy);
   endtask

   task automatic rest_sender(input bit idle_on);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send(input logic [2:0] op, input logic [NUMBER_W-1:0] number,
                       input logic [PAYLOAD_W-1:0] payload);
      issue_command(op, number, payload);
      rest_sender(1'b1);
   endtask

   // Hold the sender until every outstanding result is back and the block is quiet.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (CSR_GAP) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [CSR_DAT_W-1:0] limit_word,
                                input logic [CSR_DAT_W-1:0] margin_word,
                                input logic [CSR_DAT_W-1:0] threshold_word,
                                input bit touch_spare);
      csr_write(CSR_LOOKBACK_LIMIT, limit_word);
      csr_write(CSR_REORDER_MARGIN, margin_word);
      csr_write(CSR_WRAP_THRESHOLD, threshold_word);
      if (touch_spare) csr_write(CSR_SPARE, CSR_DAT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int items, input bit drains_on, input bit idle_on);
      int                   done;
      int                   pick;
      int                   r;
      logic [2:0]           op;
      logic [NUMBER_W-1:0]  number;
      logic [PAYLOAD_W-1:0] payload;
      done = 0;
      while (done < items) begin
         pick    = $urandom_range(0, 99);
         r       = $urandom_range(0, 19);
         number  = NUMBER_W'($urandom);
         payload = {$urandom, $urandom};
         if (pick < 48) begin
            op = OP_PUSH;
            if (r == 0) begin
               seq_next = number + 1'b1;
            end else if (r < 3) begin
               number = seq_next - NUMBER_W'($urandom_range(1, 8));
            end else begin
               number   = seq_next;
               seq_next = seq_next + 1'b1;
            end
            seq_last = number;
         end else if (pick < 72 || pick >= 93) begin
            op = OP_LOOKUP;
            if (r < 3) number = seq_last;
            else if (r < 16) number = seq_last - NUMBER_W'($urandom_range(1, 90));
            else if (r < 18) number = seq_last + NUMBER_W'($urandom_range(1, 20));
         end else if (pick < 80) begin
            op = OP_LATEST;
         end else if (pick < 86) begin
            op = OP_SIZE;
         end else if (pick < 90) begin
            op = drains_on ? OP_DRAIN : OP_LATEST;
         end else begin
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end
         issue_command(op, number, payload);
         if (op < OP_SPARE_FIRST) done++;
         if (idle_on && $urandom_range(0, 79) == 0) wait_drained();
         else rest_sender(idle_on);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty ring, ignored opcodes, then a short fill with hits, misses and a drain.
      send(OP_LATEST, '0, '0);
      send(OP_LOOKUP, '0, '0);
      send(OP_DRAIN, '0, '0);
      send(OP_SIZE, '0, '0);
      for (logic [3:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send(op[2:0], '1, '1);
      send(OP_PUSH, 16'hFFFF, '1);
      send(OP_PUSH, 16'h0000, '0);
      send(OP_PUSH, 16'd100, {$urandom, $urandom});
      send(OP_PUSH, 16'd101, {$urandom, $urandom});
      send(OP_PUSH, 16'd102, {$urandom, $urandom});
      send(OP_LATEST, '0, '0);
      send(OP_LOOKUP, 16'd102, '0);
      send(OP_LOOKUP, 16'd100, '0);
      send(OP_LOOKUP, 16'hFFFF, '0);
      send(OP_LOOKUP, 16'd40, '0);
      send(OP_SIZE, '0, '0);
      send(OP_DRAIN, '0, '0);
      // after the drain the scan reaches a slot left over from before it
      send(OP_PUSH, 16'd159, {$urandom, $urandom});
      send(OP_LOOKUP, 16'd102, '0);
      // packet numbers wrapping past zero fold the distance
      send(OP_PUSH, 16'd65530, {$urandom, $urandom});
      send(OP_PUSH, 16'd3, {$urandom, $urandom});
      send(OP_LOOKUP, 16'd65530, '0);
      send(OP_DRAIN, '0, '0);

      seq_next = NUMBER_W'($urandom);
      seq_last = seq_next;
      run_phase(70, 1'b1, 1'b1);

      wait_drained();
      load_settings('0, '0, '0, 1'b1);
      run_phase(40, 1'b1, 1'b1);

      // Widest window; no drains, so the ring can fill and overwrite, then a full drain.
      wait_drained();
      load_settings(16'd255, 16'd15, 16'hFFFF, 1'b0);
      seq_next = 16'd65500;
      seq_last = 16'd65499;
      run_phase(100, 1'b0, 1'b1);
      issue_command(OP_DRAIN, '0, '0);

      wait_drained();
      load_settings(CSR_DAT_W'($urandom), CSR_DAT_W'($urandom),
                    CSR_DAT_W'($urandom_range(60000, 65535)), 1'b0);
      run_phase(50, 1'b1, 1'b1);

      wait_drained();
      load_settings(CSR_DAT_W'($urandom), CSR_DAT_W'($urandom), CSR_DAT_W'($urandom), 1'b1);
      run_phase(50, 1'b1, 1'b1);

      wait_drained();
      load_settings(LOOKBACK_LIMIT_RESET, REORDER_MARGIN_RESET, WRAP_THRESHOLD_RESET, 1'b0);
      run_phase(40, 1'b1, 1'b0);

      start <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
